### design/lroc_pkg.sv
// Shared types and constants for the line raster overlap counter.
// No dependencies; used by every module of the block by scoped name.
package lroc_pkg;

  localparam int GRID_DIM = 1024;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 21;
  localparam int GRID_W = $clog2(GRID_DIM);
  localparam int EXT_W = (GRID_W > COORD_W) ? GRID_W : COORD_W;
  localparam int ADDR_W = 2 * GRID_W;
  localparam int CELL_DEPTH = 1 << ADDR_W;
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W = $clog2(Q_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [1:0] KIND_DRAW = 2'd0;
  localparam logic [1:0] KIND_SKIP = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [1:0] kind;
    coord_t     x_start;
    coord_t     y_start;
    coord_t     x_end;
    coord_t     y_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic initializing;
  } back_status_t;

endpackage

### design/lroc_front.sv
// Front end: takes command words, holds the diagonal mode register and
// classifies each word as draw, skip or clear. Depends on lroc_pkg.
module lroc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  lroc_pkg::coord_t      in_x_start,
  input  lroc_pkg::coord_t      in_y_start,
  input  lroc_pkg::coord_t      in_x_end,
  input  lroc_pkg::coord_t      in_y_end,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_include_diagonals,
  input  lroc_pkg::q_status_t   q_status,
  input  lroc_pkg::back_status_t back_status,
  output logic                  push,
  output lroc_pkg::job_t        push_job
);

  logic incl_diag_r;
  logic incl_diag_nxt;
  logic straight;

  always_comb begin
    incl_diag_nxt = cfg_wr_en ? cfg_include_diagonals : incl_diag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incl_diag_r <= 1'b1;
    end else begin
      incl_diag_r <= incl_diag_nxt;
    end
  end

  assign busy = q_status.full | back_status.initializing;
  assign push = start & ~busy;
  assign straight = (in_x_start == in_x_end) || (in_y_start == in_y_end);

  always_comb begin
    push_job.x_start = in_x_start;
    push_job.y_start = in_y_start;
    push_job.x_end = in_x_end;
    push_job.y_end = in_y_end;
    priority if (in_command) begin
      push_job.kind = lroc_pkg::KIND_CLEAR;
    end else if (incl_diag_r || straight) begin
      push_job.kind = lroc_pkg::KIND_DRAW;
    end else begin
      push_job.kind = lroc_pkg::KIND_SKIP;
    end
  end

endmodule

### design/lroc_queue.sv
// Short job queue between front and back ends.
// Depends on lroc_pkg for the job word and queue status types.
module lroc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lroc_pkg::job_t      push_job,
  input  logic                pop,
  output lroc_pkg::job_t      pop_job,
  output lroc_pkg::q_status_t status
);

  lroc_pkg::job_t              slot_r [lroc_pkg::Q_DEPTH];
  logic [lroc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lroc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lroc_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign status.full = (cnt_r == (lroc_pkg::QPTR_W + 1)'(lroc_pkg::Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push = push & ~status.full;
  assign do_pop = pop & ~status.empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### design/lroc_back.sv
// Back end: walks segments through the hit-count memory with a
// read-then-write pipeline, sweeps the memory on reset and clear, and
// keeps the overlap count. Depends on lroc_pkg.
module lroc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  lroc_pkg::job_t                job,
  output logic                          pop,
  output lroc_pkg::back_status_t        status,
  output logic                          out_valid,
  output logic [lroc_pkg::COUNT_W-1:0]  out_overlap_count
);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  localparam int CMP_W = lroc_pkg::EXT_W + 1;
  localparam logic [CMP_W-1:0] DIM_C = CMP_W'(lroc_pkg::GRID_DIM);
  localparam logic [lroc_pkg::ADDR_W-1:0] LAST_ADDR = {lroc_pkg::ADDR_W{1'b1}};

  logic [1:0] mem [lroc_pkg::CELL_DEPTH];

  logic [1:0]                    state_r, state_nxt;
  lroc_pkg::coord_t              x_r, x_nxt, y_r, y_nxt;
  lroc_pkg::coord_t              xe_r, xe_nxt, ye_r, ye_nxt;
  logic [lroc_pkg::ADDR_W-1:0]   sweep_r, sweep_nxt;
  logic [lroc_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          w_vld_r, w_vld_nxt;
  logic                          w_last_r, w_last_nxt;
  logic                          w_in_r, w_in_nxt;
  logic [lroc_pkg::ADDR_W-1:0]   w_addr_r, w_addr_nxt;
  logic                          byp_r, byp_nxt;
  logic [1:0]                    byp_val_r;
  logic [1:0]                    rdata_r;
  logic                          out_vld_r, out_vld_nxt;
  logic [lroc_pkg::COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic                          rd_en;
  logic [lroc_pkg::ADDR_W-1:0]   rd_addr;
  logic                          we;
  logic [lroc_pkg::ADDR_W-1:0]   waddr;
  logic [1:0]                    wdata;
  logic [1:0]                    old_hits;
  logic                          cell_we;
  logic [1:0]                    cell_new;
  logic [lroc_pkg::COUNT_W-1:0]  cnt_walk;
  logic [lroc_pkg::EXT_W-1:0]    x_ext, y_ext;
  logic                          at_end;
  logic                          in_grid;

  assign x_ext = lroc_pkg::EXT_W'(x_r);
  assign y_ext = lroc_pkg::EXT_W'(y_r);
  assign in_grid = (CMP_W'(x_r) < DIM_C) && (CMP_W'(y_r) < DIM_C);
  assign at_end = (x_r == xe_r) && (y_r == ye_r);
  assign rd_addr = {y_ext[lroc_pkg::GRID_W-1:0], x_ext[lroc_pkg::GRID_W-1:0]};
  assign rd_en = (state_r == ST_WALK);

  // write stage of the cell pipeline
  always_comb begin
    old_hits = byp_r ? byp_val_r : rdata_r;
    cell_we = w_vld_r && w_in_r && (old_hits < 2'd2);
    cell_new = old_hits + 2'd1;
    cnt_walk = cnt_r;
    if (cell_we && (cell_new == 2'd2) && (cnt_r != lroc_pkg::COUNT_MAX)) begin
      cnt_walk = cnt_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    xe_nxt = xe_r;
    ye_nxt = ye_r;
    sweep_nxt = sweep_r;
    cnt_nxt = cnt_walk;
    w_vld_nxt = 1'b0;
    w_last_nxt = 1'b0;
    w_in_nxt = in_grid;
    w_addr_nxt = rd_addr;
    out_vld_nxt = 1'b0;
    out_cnt_nxt = out_cnt_r;
    pop = 1'b0;
    we = cell_we;
    waddr = w_addr_r;
    wdata = cell_new;

    if (w_vld_r && w_last_r) begin
      out_vld_nxt = 1'b1;
      out_cnt_nxt = cnt_walk;
    end

    unique case (state_r)
      ST_INIT, ST_CLR: begin
        we = 1'b1;
        waddr = sweep_r;
        wdata = 2'd0;
        sweep_nxt = sweep_r + 1'b1;
        cnt_nxt = '0;
        if (sweep_r == LAST_ADDR) begin
          if (state_r == ST_CLR) begin
            out_vld_nxt = 1'b1;
            out_cnt_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && !w_vld_r) begin
          pop = 1'b1;
          x_nxt = job.x_start;
          y_nxt = job.y_start;
          xe_nxt = job.x_end;
          ye_nxt = job.y_end;
          sweep_nxt = '0;
          unique case (job.kind)
            lroc_pkg::KIND_DRAW: state_nxt = ST_WALK;
            lroc_pkg::KIND_CLEAR: state_nxt = ST_CLR;
            default: begin
              out_vld_nxt = 1'b1;
              out_cnt_nxt = cnt_r;
            end
          endcase
        end
      end
      default: begin
        w_vld_nxt = 1'b1;
        w_last_nxt = at_end;
        if (x_r < xe_r) begin
          x_nxt = x_r + 1'b1;
        end else if (x_r > xe_r) begin
          x_nxt = x_r - 1'b1;
        end
        if (y_r < ye_r) begin
          y_nxt = y_r + 1'b1;
        end else if (y_r > ye_r) begin
          y_nxt = y_r - 1'b1;
        end
        if (at_end) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase

    // same-cell read while written: take the written value next cycle
    byp_nxt = rd_en && cell_we && (w_addr_r == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      sweep_r <= '0;
      cnt_r <= '0;
      w_vld_r <= 1'b0;
      byp_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      cnt_r <= cnt_nxt;
      w_vld_r <= w_vld_nxt;
      byp_r <= byp_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    xe_r <= xe_nxt;
    ye_r <= ye_nxt;
    w_last_r <= w_last_nxt;
    w_in_r <= w_in_nxt;
    w_addr_r <= w_addr_nxt;
    byp_val_r <= cell_new;
    out_cnt_r <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign status.initializing = (state_r == ST_INIT);
  assign out_valid = out_vld_r;
  assign out_overlap_count = out_cnt_r;

endmodule

### design/line_raster_overlap_counter_unit.sv
// Line raster overlap counter: front end, job queue and back end.
// A segment is queued on start and walked by the back end, once idle, one
// cell per cycle; a skipped segment gives its word straight from idle. A
// clear sweeps the grid memory one cell a cycle over all GRID_DIM*GRID_DIM
// cells. Reset (rst_n low, synchronous) runs the same sweep with busy high.
// Results are one-cycle strobes.
module line_raster_overlap_counter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  lroc_pkg::coord_t              in_x_start,
  input  lroc_pkg::coord_t              in_y_start,
  input  lroc_pkg::coord_t              in_x_end,
  input  lroc_pkg::coord_t              in_y_end,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_include_diagonals,
  output logic                          out_valid,
  output logic [lroc_pkg::COUNT_W-1:0]  out_overlap_count
);

  logic                   push;
  lroc_pkg::job_t         push_job;
  logic                   pop;
  lroc_pkg::job_t         pop_job;
  lroc_pkg::q_status_t    q_status;
  lroc_pkg::back_status_t back_status;

  lroc_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_x_start            (in_x_start),
    .in_y_start            (in_y_start),
    .in_x_end              (in_x_end),
    .in_y_end              (in_y_end),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_include_diagonals (cfg_include_diagonals),
    .q_status              (q_status),
    .back_status           (back_status),
    .push                  (push),
    .push_job              (push_job)
  );

  lroc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  lroc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_status.empty),
    .job               (pop_job),
    .pop               (pop),
    .status            (back_status),
    .out_valid         (out_valid),
    .out_overlap_count (out_overlap_count)
  );

endmodule
